[rtl/rase_pkg.sv]
package rase_pkg;

   localparam int REGISTER_COUNT_DEF = 32;
   localparam int MEMORY_DEPTH_DEF   = 65536;
   localparam int DATA_W             = 32;
   localparam int UPPER_SHIFT        = 16;
   localparam int CSR_INDEX_W        = 2;
   localparam int MEMORY_BYTES_W     = 17;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_AND   = 4'd1;
   localparam logic [3:0] OP_OR    = 4'd2;
   localparam logic [3:0] OP_XOR   = 4'd3;
   localparam logic [3:0] OP_REMU  = 4'd4;
   localparam logic [3:0] OP_ADDI  = 4'd5;
   localparam logic [3:0] OP_ORI   = 4'd6;
   localparam logic [3:0] OP_LUI   = 4'd7;
   localparam logic [3:0] OP_STORE = 4'd8;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_MEM_TRAP  = 3'd1;
   localparam logic [2:0] STS_MMIO_TRAP = 3'd2;
   localparam logic [2:0] STS_UNHANDLED = 3'd3;
   localparam logic [2:0] STS_HALTED    = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MMIO_MASK    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STDOUT_ADDR  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEMORY_BYTES = 2'd2;

   localparam logic [DATA_W-1:0]         MMIO_MASK_RESET    = 32'h8000_0000;
   localparam logic [DATA_W-1:0]         STDOUT_ADDR_RESET  = 32'h8000_0000;
   localparam logic [MEMORY_BYTES_W-1:0] MEMORY_BYTES_RESET = 17'h1_0000;

   typedef struct packed {
      logic [3:0]         op;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_a;
      logic [4:0]         src_reg_b;
      logic signed [15:0] imm;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic              reg_write;
      logic [4:0]        reg_index;
      logic [DATA_W-1:0] reg_value;
      logic              mem_write;
      logic [DATA_W-1:0] mem_addr;
      logic [DATA_W-1:0] mem_data;
      logic              char_valid;
      logic [7:0]        char_out;
   } rsp_type;

endpackage

[rtl/register_alu_store_executor.sv]
// order: a taken word becomes the current word, then its result is registered once the
// output is free; unsigned remainder by non-zero divisor first runs the bit-serial divider
// throughput: one word per cycle while the output takes each result and no division runs
// register file lives in two mirrored registered RAMs, with forwarding of the last write
// reset (synchronous): registers read as zero, halt clears, csr take their reset values;
// data memory is not cleared and no clearing pass runs
module register_alu_store_executor #(
   parameter int REGISTER_COUNT = rase_pkg::REGISTER_COUNT_DEF,
   parameter int MEMORY_DEPTH   = rase_pkg::MEMORY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rase_pkg::req_type                   req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rase_pkg::rsp_type                   rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rase_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rase_pkg::DATA_W-1:0]         csr_data
);
   import rase_pkg::*;

   localparam int RA_W  = $clog2(REGISTER_COUNT);
   localparam int ROWS  = (MEMORY_DEPTH + 3) / 4;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(DATA_W);
   localparam logic [DATA_W:0]  DEPTH_LIMIT = (DATA_W + 1)'(MEMORY_DEPTH);
   localparam logic [CNT_W-1:0] LAST_STEP   = CNT_W'(DATA_W - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]                state_ff, state_in;
   req_type                   cur_ff, cur_in;
   rsp_type                   rsp_word_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      halted_ff, halted_in;
   logic [REGISTER_COUNT-1:0] reg_valid_ff, reg_valid_in;
   logic                      fwd_hit_ff, fwd_hit_in;
   logic [RA_W-1:0]           fwd_idx_ff, fwd_idx_in;
   logic [DATA_W-1:0]         fwd_val_ff, fwd_val_in;
   logic [DATA_W-1:0]         mmio_mask_ff, mmio_mask_in;
   logic [DATA_W-1:0]         stdout_addr_ff, stdout_addr_in;
   logic [MEMORY_BYTES_W-1:0] memory_bytes_ff, memory_bytes_in;
   logic [DATA_W-1:0]         rem_ff, rem_in;
   logic [DATA_W-1:0]         quo_ff, quo_in;
   logic [DATA_W-1:0]         dvs_ff, dvs_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic              req_accept, out_free, complete, need_div, set_halt;
   logic              reg_we, mem_we, alu_we;
   logic [RA_W-1:0]   ram_a_addr, ram_b_addr;
   logic [DATA_W-1:0] ram_a_data, ram_b_data;
   logic [4:0]        idx_a, idx_b;
   logic [DATA_W-1:0] opa, opb, imm_sx, alu_v, st_addr;
   logic              mmio_hit, mem_oob;
   logic [DATA_W:0]   limit, end_addr, rem_sh, rem_diff;
   logic [1:0]        lane_off [4];
   logic [DATA_W-1:0] lane_byte_addr [4];
   logic [ROW_W-1:0]  lane_row [4];
   logic [7:0]        lane_data [4];

   // register file, mirrored for two read ports
   assign ram_a_addr = req_word.src_reg_a[RA_W-1:0];
   assign ram_b_addr = (req_word.op == OP_STORE) ? req_word.dest_reg[RA_W-1:0]
                                                 : req_word.src_reg_b[RA_W-1:0];

   rase_ram #(.WIDTH(DATA_W), .DEPTH(REGISTER_COUNT)) u_regs_a (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (rsp_in.reg_index[RA_W-1:0]),
      .wr_data (rsp_in.reg_value),
      .rd_en   (req_accept),
      .rd_addr (ram_a_addr),
      .rd_data (ram_a_data)
   );

   rase_ram #(.WIDTH(DATA_W), .DEPTH(REGISTER_COUNT)) u_regs_b (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (rsp_in.reg_index[RA_W-1:0]),
      .wr_data (rsp_in.reg_value),
      .rd_en   (req_accept),
      .rd_addr (ram_b_addr),
      .rd_data (ram_b_data)
   );

   // operands: forwarded write, then stored word, else zero
   always_comb begin
      idx_a = cur_ff.src_reg_a;
      idx_b = (cur_ff.op == OP_STORE) ? cur_ff.dest_reg : cur_ff.src_reg_b;
      if (int'(idx_a) >= REGISTER_COUNT) begin
         opa = '0;
      end else if (fwd_hit_ff && fwd_idx_ff == idx_a[RA_W-1:0]) begin
         opa = fwd_val_ff;
      end else if (reg_valid_ff[idx_a[RA_W-1:0]]) begin
         opa = ram_a_data;
      end else begin
         opa = '0;
      end
      if (int'(idx_b) >= REGISTER_COUNT) begin
         opb = '0;
      end else if (fwd_hit_ff && fwd_idx_ff == idx_b[RA_W-1:0]) begin
         opb = fwd_val_ff;
      end else if (reg_valid_ff[idx_b[RA_W-1:0]]) begin
         opb = ram_b_data;
      end else begin
         opb = '0;
      end
   end

   assign imm_sx = DATA_W'(cur_ff.imm);

   always_comb begin
      alu_v  = '0;
      alu_we = 1'b1;
      unique case (cur_ff.op)
         OP_ADD:  alu_v = opa + opb;
         OP_AND:  alu_v = opa & opb;
         OP_OR:   alu_v = opa | opb;
         OP_XOR:  alu_v = opa ^ opb;
         OP_REMU: alu_v = opa;
         OP_ADDI: alu_v = opa + imm_sx;
         OP_ORI:  alu_v = opa | imm_sx;
         OP_LUI:  alu_v = opa | (DATA_W'(unsigned'(cur_ff.imm)) << UPPER_SHIFT);
         default: alu_we = 1'b0;
      endcase
   end

   assign need_div = (cur_ff.op == OP_REMU) && (opb != '0);

   // store address checks
   assign st_addr  = opa + imm_sx;
   assign mmio_hit = (st_addr & mmio_mask_ff) != '0;
   assign limit    = ((DATA_W + 1)'(memory_bytes_ff) > DEPTH_LIMIT)
                     ? DEPTH_LIMIT : (DATA_W + 1)'(memory_bytes_ff);
   assign end_addr = {1'b0, st_addr} + (DATA_W + 1)'(4);
   assign mem_oob  = end_addr > limit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign complete  = out_free && ((state_ff == ST_EXEC && (halted_ff || !need_div))
                                   || state_ff == ST_FIN);
   assign req_ready = (state_ff == ST_IDLE) || complete;
   assign req_accept = req_valid && req_ready;

   // result word
   always_comb begin
      rsp_in   = '0;
      set_halt = 1'b0;
      if (state_ff == ST_FIN) begin
         if (int'(cur_ff.dest_reg) < REGISTER_COUNT) begin
            rsp_in.reg_write = 1'b1;
            rsp_in.reg_index = cur_ff.dest_reg;
            rsp_in.reg_value = rem_ff;
         end
      end else if (halted_ff) begin
         rsp_in.status = STS_HALTED;
      end else if (alu_we) begin
         if (int'(cur_ff.dest_reg) < REGISTER_COUNT) begin
            rsp_in.reg_write = 1'b1;
            rsp_in.reg_index = cur_ff.dest_reg;
            rsp_in.reg_value = alu_v;
         end
      end else if (cur_ff.op == OP_STORE) begin
         rsp_in.mem_addr = st_addr;
         rsp_in.mem_data = opb;
         if (!mmio_hit) begin
            if (mem_oob) begin
               rsp_in.status = STS_MEM_TRAP;
               set_halt      = 1'b1;
            end else begin
               rsp_in.mem_write = 1'b1;
            end
         end else if (st_addr == stdout_addr_ff) begin
            rsp_in.char_valid = 1'b1;
            rsp_in.char_out   = opb[7:0];
         end else begin
            rsp_in.status = STS_MMIO_TRAP;
            set_halt      = 1'b1;
         end
      end else begin
         rsp_in.status = STS_UNHANDLED;
      end
   end

   assign reg_we = complete && rsp_in.reg_write;
   assign mem_we = complete && rsp_in.mem_write;

   // data memory: four byte lanes, little-endian, any alignment
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lane_off[l]       = 2'(l) - st_addr[1:0];
         lane_byte_addr[l] = st_addr + DATA_W'(lane_off[l]);
         lane_row[l]       = lane_byte_addr[l][ROW_W+1:2];
         lane_data[l]      = 8'(opb >> {lane_off[l], 3'b000});
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      rase_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bytes (
         .clock   (clock),
         .wr_en   (mem_we),
         .wr_addr (lane_row[g]),
         .wr_data (lane_data[g]),
         .rd_en   (1'b0),
         .rd_addr (lane_row[g]),
         .rd_data ()
      );
   end

   // bit-serial remainder
   assign rem_sh   = {rem_ff, quo_ff[DATA_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      state_in     = state_ff;
      cur_in       = req_accept ? req_word : cur_ff;
      rsp_valid_in = complete ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      halted_in    = halted_ff || (complete && set_halt);
      reg_valid_in = reg_valid_ff;
      fwd_hit_in   = req_accept ? reg_we : fwd_hit_ff;
      fwd_idx_in   = reg_we ? rsp_in.reg_index[RA_W-1:0] : fwd_idx_ff;
      fwd_val_in   = reg_we ? rsp_in.reg_value : fwd_val_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      if (reg_we) begin
         reg_valid_in[rsp_in.reg_index[RA_W-1:0]] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!halted_ff && need_div) begin
               state_in = ST_DIV;
               rem_in   = '0;
               quo_in   = opa;
               dvs_in   = opb;
               cnt_in   = '0;
            end else if (complete) begin
               state_in = req_accept ? ST_EXEC : ST_IDLE;
            end
         end
         ST_DIV: begin
            quo_in = quo_ff << 1;
            rem_in = (rem_sh >= {1'b0, dvs_ff}) ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (complete) begin
               state_in = req_accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      mmio_mask_in    = mmio_mask_ff;
      stdout_addr_in  = stdout_addr_ff;
      memory_bytes_in = memory_bytes_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MMIO_MASK:    mmio_mask_in    = csr_data;
            CSR_STDOUT_ADDR:  stdout_addr_in  = csr_data;
            CSR_MEMORY_BYTES: memory_bytes_in = csr_data[MEMORY_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         halted_ff       <= 1'b0;
         reg_valid_ff    <= '0;
         fwd_hit_ff      <= 1'b0;
         mmio_mask_ff    <= MMIO_MASK_RESET;
         stdout_addr_ff  <= STDOUT_ADDR_RESET;
         memory_bytes_ff <= MEMORY_BYTES_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         halted_ff       <= halted_in;
         reg_valid_ff    <= reg_valid_in;
         fwd_hit_ff      <= fwd_hit_in;
         mmio_mask_ff    <= mmio_mask_in;
         stdout_addr_ff  <= stdout_addr_in;
         memory_bytes_ff <= memory_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      fwd_idx_ff <= fwd_idx_in;
      fwd_val_ff <= fwd_val_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      if (complete) begin
         rsp_word_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/rase_ram.sv]
module rase_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rase_checker.sv]
module rase_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rase_pkg::rsp_type rsp_word
);
   import rase_pkg::*;

   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       trap_seen_ff, trap_seen_in;

   // words taken but not yet delivered
   always_comb begin
      out_cnt_in = out_cnt_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
      trap_seen_in = trap_seen_ff
                     || (rsp_valid && rsp_ready
                         && (rsp_word.status == STS_MEM_TRAP
                             || rsp_word.status == STS_MMIO_TRAP));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff   <= '0;
         trap_seen_ff <= 1'b0;
      end else begin
         out_cnt_ff   <= out_cnt_in;
         trap_seen_ff <= trap_seen_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed while stalled");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      trap_seen_ff && rsp_valid |-> rsp_word.status == STS_HALTED)
      else $error("word executed after a trap");

   a_no_side_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STS_OK
      |-> !rsp_word.reg_write && !rsp_word.mem_write && !rsp_word.char_valid)
      else $error("failed word changed state");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3 && (!rsp_valid || out_cnt_ff != 2'd0))
      else $error("result without a word or too many words in flight");

endmodule

bind register_alu_store_executor rase_checker u_rase_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import rase_pkg::*;

   localparam int REGS           = REGISTER_COUNT_DEF;
   localparam int WORD_BYTES     = 4;
   localparam int IMM_REACH      = 32767;
   localparam int UPPER_STEP     = 1 << UPPER_SHIFT;
   localparam int RESET_CYCLES   = 4;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [3:0] OP_LAST = 4'd15;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]      csr_data  = '0;

   // predicted architectural state
   logic [31:0] gpr_q [REGS];
   logic        halt_q      = 1'b0;
   logic [31:0] mmio_mask_q = MMIO_MASK_RESET;
   logic [31:0] stdout_q    = STDOUT_ADDR_RESET;
   logic [16:0] mem_bytes_q = MEMORY_BYTES_RESET;

   rsp_type     due_results [$];
   int unsigned mismatches = 0;
   int unsigned issued = 0, checked = 0, mem_words = 0, chars = 0, csr_writes = 0;
   int unsigned quiet_cycles = 0;
   int unsigned rsp_hold = 0;
   int          holds_asked = 0, holds_done = 0;
   bit          req_idle = 1'b0, rsp_idle = 1'b0;

   register_alu_store_executor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < REGS; i++) gpr_q[i] = '0;
   end

   function automatic int unsigned idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(0, 3);
   endfunction

   function automatic int unsigned usable_bytes();
      return (mem_bytes_q > MEMORY_DEPTH_DEF) ? MEMORY_DEPTH_DEF : mem_bytes_q;
   endfunction

   function automatic logic [31:0] reg_read(input logic [4:0] idx);
      return (idx < REGS) ? gpr_q[idx] : '0;
   endfunction

   function automatic req_type make_instr(input logic [3:0] op, input logic [4:0] rd,
                                          input logic [4:0] ra, input logic [4:0] rb,
                                          input logic [15:0] imm);
      req_type w;
      w.op        = op;
      w.dest_reg  = rd;
      w.src_reg_a = ra;
      w.src_reg_b = rb;
      w.imm       = imm;
      return w;
   endfunction

   // executes one instruction on the predicted state and returns its result word
   function automatic rsp_type run_instr(input req_type w);
      rsp_type     r;
      logic [31:0] a, b, v, sx, addr, data;
      bit          writes;
      r = '0;
      if (halt_q) begin
         r.status = STS_HALTED;
         return r;
      end
      a      = reg_read(w.src_reg_a);
      b      = reg_read(w.src_reg_b);
      sx     = {{16{w.imm[15]}}, w.imm};
      v      = '0;
      writes = 1'b1;
      case (w.op)
         OP_ADD:  v = a + b;
         OP_AND:  v = a & b;
         OP_OR:   v = a | b;
         OP_XOR:  v = a ^ b;
         OP_REMU: v = (b == '0) ? a : a % b;
         OP_ADDI: v = a + sx;
         OP_ORI:  v = a | sx;
         OP_LUI:  v = a | ({16'h0, w.imm} << UPPER_SHIFT);
         default: writes = 1'b0;
      endcase
      if (writes) begin
         if (w.dest_reg < REGS) begin
            gpr_q[w.dest_reg] = v;
            r.reg_write = 1'b1;
            r.reg_index = w.dest_reg;
            r.reg_value = v;
         end
         return r;
      end
      if (w.op == OP_STORE) begin
         addr       = a + sx;
         data       = reg_read(w.dest_reg);
         r.mem_addr = addr;
         r.mem_data = data;
         if ((addr & mmio_mask_q) == '0) begin
            if (64'(addr) + WORD_BYTES > 64'(usable_bytes())) begin
               r.status = STS_MEM_TRAP;
               halt_q   = 1'b1;
            end else begin
               r.mem_write = 1'b1;
               mem_words++;
            end
         end else if (addr == stdout_q) begin
            r.char_valid = 1'b1;
            r.char_out   = data[7:0];
            chars++;
         end else begin
            r.status = STS_MMIO_TRAP;
            halt_q   = 1'b1;
         end
         return r;
      end
      r.status = STS_UNHANDLED;
      return r;
   endfunction

   task automatic issue_instr(input req_type w);
      int unsigned gap;
      gap = 0;
      if (req_idle && $urandom_range(0, 2) == 0) gap = idle_len() + 1;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      due_results.push_back(run_instr(w));
      issued++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   task automatic apply_config(input logic [31:0] mask, input logic [31:0] out_addr,
                               input logic [31:0] bytes_word, input bit spare);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [31:0]            val [4];
      int                     n, i;
      idx = '{CSR_MMIO_MASK, CSR_STDOUT_ADDR, CSR_MEMORY_BYTES, CSR_SPARE};
      val = '{mask, out_addr, bytes_word, $urandom};
      n   = spare ? 4 : 3;
      wait_drained();
      for (i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_MMIO_MASK:    mmio_mask_q = val[i];
            CSR_STDOUT_ADDR:  stdout_q    = val[i];
            CSR_MEMORY_BYTES: mem_bytes_q = val[i][MEMORY_BYTES_W-1:0];
            default: ;
         endcase
         csr_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_alu();
      logic [3:0] ops [7];
      ops = '{OP_ADD, OP_AND, OP_OR, OP_XOR, OP_ADDI, OP_ORI, OP_LUI};
      return make_instr(ops[$urandom_range(0, 6)], 5'($urandom), 5'($urandom),
                        5'($urandom), 16'($urandom));
   endfunction

   // clear a pointer, load a base that reaches a safe address, then store through it
   task automatic issue_store_sequence(output int unsigned n);
      logic [4:0]  ptr, src;
      logic [31:0] target, base;
      logic [15:0] offset;
      bit          can_mem, can_out, to_out;
      int unsigned lim, floor_b;
      lim     = usable_bytes();
      can_mem = lim >= WORD_BYTES;
      can_out = (stdout_q & mmio_mask_q) != '0;
      if (!can_mem && !can_out) begin
         issue_instr(random_alu());
         n = 1;
         return;
      end
      to_out = can_out && (!can_mem || $urandom_range(0, 3) == 0);
      ptr    = 5'($urandom);
      src    = 5'($urandom);
      issue_instr(make_instr(OP_XOR, ptr, ptr, ptr, 16'($urandom)));
      if (to_out) begin
         offset = stdout_q[15:0];
         base   = stdout_q - {{16{offset[15]}}, offset};
         issue_instr(make_instr(OP_LUI, ptr, ptr, 5'($urandom), base[31:16]));
      end else begin
         target  = $urandom_range(0, lim - WORD_BYTES) & ~mmio_mask_q;
         floor_b = (target > IMM_REACH) ? target - IMM_REACH : 0;
         base    = $urandom_range(floor_b, IMM_REACH);
         offset  = 16'(target - base);
         issue_instr(make_instr(OP_ADDI, ptr, ptr, 5'($urandom), base[15:0]));
      end
      issue_instr(make_instr(OP_STORE, src, ptr, 5'($urandom), offset));
      n = 3;
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned sent, pick, n;
      logic [4:0]  rb;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            issue_instr(random_alu());
            sent++;
         end else if (pick < 53) begin
            rb = 5'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               issue_instr(make_instr(OP_XOR, rb, rb, rb, 16'($urandom)));
               sent++;
            end
            issue_instr(make_instr(OP_REMU, 5'($urandom), 5'($urandom), rb, 16'($urandom)));
            sent++;
         end else if (pick < 88) begin
            issue_store_sequence(n);
            sent += n;
         end else begin
            issue_instr(make_instr(4'($urandom_range(OP_STORE + 1, OP_LAST)), 5'($urandom),
                                   5'($urandom), 5'($urandom), 16'($urandom)));
            sent++;
         end
      end
   endtask

   task automatic test_directed_ops();
      int op;
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      issue_instr(make_instr(OP_LUI,  5'd1,  5'd0,  5'd0,  16'hFFFF));
      issue_instr(make_instr(OP_ORI,  5'd1,  5'd1,  5'd0,  16'hFFFF));
      issue_instr(make_instr(OP_ADDI, 5'd2,  5'd0,  5'd0,  16'h7FFF));
      issue_instr(make_instr(OP_ADDI, 5'd3,  5'd0,  5'd0,  16'h8000));
      issue_instr(make_instr(OP_ADD,  5'd4,  5'd1,  5'd2,  16'h0000));
      issue_instr(make_instr(OP_AND,  5'd5,  5'd1,  5'd3,  16'h0000));
      issue_instr(make_instr(OP_OR,   5'd6,  5'd2,  5'd3,  16'h0000));
      issue_instr(make_instr(OP_XOR,  5'd7,  5'd1,  5'd2,  16'h0000));
      issue_instr(make_instr(OP_REMU, 5'd8,  5'd1,  5'd2,  16'h0000));
      // divisor register still zero
      issue_instr(make_instr(OP_REMU, 5'd9,  5'd1,  5'd12, 16'h0000));
      issue_instr(make_instr(OP_REMU, 5'd10, 5'd2,  5'd1,  16'h0000));
      // register zero is writable
      issue_instr(make_instr(OP_ADDI, 5'd0,  5'd0,  5'd0,  16'h0005));
      issue_instr(make_instr(OP_ADD,  5'd11, 5'd0,  5'd0,  16'h0000));
      issue_instr(make_instr(OP_ADD,  5'd31, 5'd31, 5'd2,  16'h0000));
      // last whole word of memory, then address zero two ways
      issue_instr(make_instr(OP_STORE, 5'd1, 5'd2,  5'd0,  16'h7FFD));
      issue_instr(make_instr(OP_STORE, 5'd7, 5'd12, 5'd31, 16'h0000));
      issue_instr(make_instr(OP_ADDI,  5'd13, 5'd12, 5'd0, 16'd100));
      issue_instr(make_instr(OP_STORE, 5'd4, 5'd13, 5'd0,  16'hFF9C));
      // character out
      issue_instr(make_instr(OP_LUI,   5'd14, 5'd12, 5'd0, 16'h8000));
      issue_instr(make_instr(OP_STORE, 5'd5, 5'd14, 5'd0,  16'h0000));
      for (op = OP_STORE + 1; op <= OP_LAST; op++)
         issue_instr(make_instr(4'(op), 5'($urandom), 5'($urandom), 5'($urandom),
                                16'($urandom)));
      wait_drained();
   endtask

   task automatic test_random_default();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      run_random(500);
   endtask

   task automatic test_output_backpressure();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      holds_asked++;
      run_random(50);
      wait_drained();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      run_random(50);
   endtask

   task automatic test_config_extremes();
      apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_FFFF, 1'b1);
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      run_random(300);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   task automatic test_config_no_mmio();
      // upper bits of the size word are dropped, leaving four bytes
      apply_config(32'h0000_0000, 32'h0000_0000, 32'hFFFE_0004, 1'b0);
      run_random(200);
   endtask

   task automatic test_config_no_memory();
      logic [31:0] mask, out_addr;
      mask     = $urandom | (32'h1 << $urandom_range(0, 31));
      out_addr = $urandom;
      if ((out_addr & mask) == '0) out_addr = out_addr | mask;
      apply_config(mask, out_addr, 32'h0, 1'b0);
      run_random(200);
   endtask

   task automatic test_config_random();
      logic [31:0] mask, out_addr;
      int          round;
      for (round = 0; round < 3; round++) begin
         mask     = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'hFFFF_0000);
         out_addr = $urandom;
         if ($urandom_range(0, 1) == 0) out_addr = out_addr | mask;
         apply_config(mask, out_addr, $urandom_range(0, MEMORY_DEPTH_DEF), round == 0);
         run_random(150);
      end
   endtask

   task automatic test_trap_and_halt();
      logic [4:0] ptr, src;
      int         i;
      apply_config(MMIO_MASK_RESET, STDOUT_ADDR_RESET, 32'(MEMORY_BYTES_RESET), 1'b0);
      ptr = 5'($urandom);
      src = 5'($urandom);
      issue_instr(make_instr(OP_XOR, ptr, ptr, ptr, 16'h0));
      if ($urandom_range(0, 1) == 0) begin
         // word running one to three bytes past the end of memory
         issue_instr(make_instr(OP_LUI, ptr, ptr, 5'd0, 16'd1));
         issue_instr(make_instr(OP_STORE, src, ptr, 5'd0,
                                16'(usable_bytes() - WORD_BYTES + $urandom_range(1, 3)
                                    - UPPER_STEP)));
      end else begin
         // mmio address other than the character port
         issue_instr(make_instr(OP_LUI, ptr, ptr, 5'd0, 16'h8000));
         issue_instr(make_instr(OP_STORE, src, ptr, 5'd0, 16'd4));
      end
      for (i = 0; i < 16; i++)
         issue_instr(make_instr(4'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                                16'($urandom)));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_random_default();
      test_output_backpressure();
      test_config_extremes();
      test_config_no_mmio();
      test_config_no_memory();
      test_config_random();
      test_trap_and_halt();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         mismatches += due_results.size();
         $display("%0d results never arrived", due_results.size());
      end
      $display("%0d instructions over %0d csr writes, %0d results checked", issued,
               csr_writes, checked);
      $display("%0d memory words and %0d characters stored, halt: %0b", mem_words, chars,
               halt_q);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // result side readiness, including the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         rsp_hold   <= 0;
         holds_done <= 0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_asked;
         rsp_ready  <= 1'b0;
         rsp_hold   <= LONG_HOLD;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (rsp_idle && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= idle_len();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("result %0d %s: expected %h, got %h", checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result word %h", rsp_word);
         end else begin
            want = due_results.pop_front();
            checked++;
            check_field("status",     32'(rsp_word.status),     32'(want.status));
            check_field("reg_write",  32'(rsp_word.reg_write),  32'(want.reg_write));
            check_field("reg_index",  32'(rsp_word.reg_index),  32'(want.reg_index));
            check_field("reg_value",  rsp_word.reg_value,       want.reg_value);
            check_field("mem_write",  32'(rsp_word.mem_write),  32'(want.mem_write));
            check_field("mem_addr",   rsp_word.mem_addr,        want.mem_addr);
            check_field("mem_data",   rsp_word.mem_data,        want.mem_data);
            check_field("char_valid", 32'(rsp_word.char_valid), 32'(want.char_valid));
            check_field("char_out",   32'(rsp_word.char_out),   32'(want.char_out));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
